@@ hw/rtl/kft_pkg.sv @@
// shared types and constants of the k-mer frequency table
package kft_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
   localparam int FILL_BITS   = ADDR_BITS + 1;
   localparam int KEY_CHARS   = 8;
   localparam int KEY_BITS    = 64;
   localparam int COUNT_BITS  = 31;

   localparam logic [KEY_BITS-1:0]   KEY_MASK  = {KEY_BITS{1'b1}} << (KEY_BITS - 8 * KEY_CHARS);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_FIND   = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic [1:0]            operation;
      logic [KEY_BITS-1:0]   key;
      logic [COUNT_BITS-1:0] frequency;
      logic [ADDR_BITS-1:0]  index;
   } req_type;

   typedef struct packed {
      logic                  found;
      logic [ADDR_BITS-1:0]  position;
      logic [KEY_BITS-1:0]   entry_key;
      logic [COUNT_BITS-1:0] entry_count;
      logic [FILL_BITS-1:0]  entries_used;
      logic [1:0]            status;
   } rsp_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]   key;
      logic [COUNT_BITS-1:0] count;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

endpackage

@@ hw/rtl/kft_ram.sv @@
// simple dual port ram with one write port and one registered read port
module kft_ram #(
   parameter int WIDTH     = 95,
   parameter int ADDR_BITS = 8
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [(1 << ADDR_BITS)];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ hw/rtl/kmer_frequency_table_core.sv @@
// top level of the k-mer frequency table: scan engine, entry memory and result register
//
// Keys and counts sit in one entry memory in order of first insertion. An append or a
// find scans the used entries through the single read port, one entry per cycle,
// and stops at the first match. A read waits on the memory; an out of range read or a
// reserved code goes straight to output. A hit on append writes the saturated sum
// back in the cycle of the match; a miss writes the new entry at the fill level, or
// reports full on a full table. The memory needs no clearing pass after reset, as
// only entries below the fill level are read. The next word is taken only once the
// result sits in the output register, so it can be taken while the result waits.
module kmer_frequency_table_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  kft_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output kft_pkg::rsp_type rsp_word
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_READ_WAIT,
      S_OUTPUT
   } state_type;

   state_type                        state_ff, state_in;
   logic [1:0]                       op_ff, op_in;
   logic [kft_pkg::KEY_BITS-1:0]     key_ff, key_in;
   logic [kft_pkg::COUNT_BITS-1:0]   freq_ff, freq_in;
   logic [kft_pkg::ADDR_BITS-1:0]    idx_ff, idx_in;
   logic [kft_pkg::FILL_BITS-1:0]    fill_ff, fill_in;
   logic [kft_pkg::ADDR_BITS-1:0]    scan_addr_ff, scan_addr_in;
   logic                             issue_done_ff, issue_done_in;
   logic                             cmp_valid_ff, cmp_valid_in;
   logic [kft_pkg::ADDR_BITS-1:0]    cmp_addr_ff, cmp_addr_in;
   kft_pkg::rsp_type                 res_ff, res_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   kft_pkg::rsp_type                 rsp_word_ff, rsp_word_in;

   logic                             wr_en;
   logic [kft_pkg::ADDR_BITS-1:0]    wr_addr;
   kft_pkg::entry_type               wr_entry;
   logic                             rd_en;
   logic [kft_pkg::ADDR_BITS-1:0]    rd_addr;
   logic [kft_pkg::ENTRY_BITS-1:0]   rd_raw;
   kft_pkg::entry_type               rd_entry;

   logic                             req_fire;
   logic                             rsp_free;
   logic [kft_pkg::COUNT_BITS:0]     sum;
   logic [kft_pkg::COUNT_BITS-1:0]   new_count;

   kft_ram #(
      .WIDTH     (kft_pkg::ENTRY_BITS),
      .ADDR_BITS (kft_pkg::ADDR_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_entry  = kft_pkg::entry_type'(rd_raw);
   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign sum       = {1'b0, rd_entry.count} + {1'b0, freq_ff};
   assign new_count = sum[kft_pkg::COUNT_BITS] ? kft_pkg::COUNT_MAX
                                               : sum[kft_pkg::COUNT_BITS-1:0];

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      freq_in       = freq_ff;
      idx_in        = idx_ff;
      fill_in       = fill_ff;
      scan_addr_in  = scan_addr_ff;
      issue_done_in = issue_done_ff;
      cmp_valid_in  = 1'b0;
      cmp_addr_in   = cmp_addr_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_word_in   = rsp_word_ff;
      wr_en         = 1'b0;
      wr_addr       = cmp_addr_ff;
      wr_entry      = '0;
      rd_en         = 1'b0;
      rd_addr       = scan_addr_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in               = req_word.operation;
               key_in              = req_word.key & kft_pkg::KEY_MASK;
               freq_in             = req_word.frequency;
               idx_in              = req_word.index;
               res_in              = '0;
               res_in.entries_used = fill_ff;
               unique case (req_word.operation)
                  kft_pkg::OP_APPEND, kft_pkg::OP_FIND: begin
                     scan_addr_in  = '0;
                     issue_done_in = (fill_ff == '0);
                     state_in      = S_SCAN;
                  end
                  kft_pkg::OP_READ: begin
                     if ({1'b0, req_word.index} < fill_ff) begin
                        rd_en    = 1'b1;
                        rd_addr  = req_word.index;
                        state_in = S_READ_WAIT;
                     end else begin
                        res_in.status = kft_pkg::ST_RANGE;
                        state_in      = S_OUTPUT;
                     end
                  end
                  default: begin
                     state_in = S_OUTPUT;
                  end
               endcase
            end
         end

         S_SCAN: begin
            if (cmp_valid_ff && (rd_entry.key == key_ff)) begin
               res_in.found     = 1'b1;
               res_in.position  = cmp_addr_ff;
               res_in.entry_key = rd_entry.key;
               if (op_ff == kft_pkg::OP_APPEND) begin
                  wr_en              = 1'b1;
                  wr_addr            = cmp_addr_ff;
                  wr_entry.key       = rd_entry.key;
                  wr_entry.count     = new_count;
                  res_in.entry_count = new_count;
               end else begin
                  res_in.entry_count = rd_entry.count;
               end
               state_in = S_OUTPUT;
            end else if (issue_done_ff && !cmp_valid_ff) begin
               if (op_ff == kft_pkg::OP_APPEND) begin
                  if (fill_ff < kft_pkg::FILL_BITS'(kft_pkg::TABLE_DEPTH)) begin
                     wr_en               = 1'b1;
                     wr_addr             = fill_ff[kft_pkg::ADDR_BITS-1:0];
                     wr_entry.key        = key_ff;
                     wr_entry.count      = freq_ff;
                     res_in.position     = fill_ff[kft_pkg::ADDR_BITS-1:0];
                     res_in.entry_key    = key_ff;
                     res_in.entry_count  = freq_ff;
                     fill_in             = fill_ff + kft_pkg::FILL_BITS'(1);
                     res_in.entries_used = fill_ff + kft_pkg::FILL_BITS'(1);
                  end else begin
                     res_in.status = kft_pkg::ST_FULL;
                  end
               end
               state_in = S_OUTPUT;
            end else if (!issue_done_ff) begin
               rd_en         = 1'b1;
               rd_addr       = scan_addr_ff;
               cmp_valid_in  = 1'b1;
               cmp_addr_in   = scan_addr_ff;
               scan_addr_in  = scan_addr_ff + kft_pkg::ADDR_BITS'(1);
               issue_done_in = ({1'b0, scan_addr_ff} == (fill_ff - kft_pkg::FILL_BITS'(1)));
            end
         end

         S_READ_WAIT: begin
            res_in.position    = idx_ff;
            res_in.entry_key   = rd_entry.key;
            res_in.entry_count = rd_entry.count;
            state_in           = S_OUTPUT;
         end

         S_OUTPUT: begin
            if (rsp_free) begin
               rsp_word_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      key_ff       <= key_in;
      freq_ff      <= freq_in;
      idx_ff       <= idx_in;
      scan_addr_ff <= scan_addr_in;
      cmp_addr_ff  <= cmp_addr_in;
      res_ff       <= res_in;
      rsp_word_ff  <= rsp_word_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         fill_ff       <= '0;
         issue_done_ff <= 1'b0;
         cmp_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         issue_done_ff <= issue_done_in;
         cmp_valid_ff  <= cmp_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

endmodule

@@ hw/rtl/kft_checker.sv @@
// port level checks of the k-mer frequency table and their bind to the top level
module kft_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input kft_pkg::req_type req_word,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input kft_pkg::rsp_type rsp_word
);

   logic rsp_fire;
   logic req_seen;

   assign rsp_fire = rsp_valid && !rsp_stall;
   assign req_seen = req_valid || req_stall || (req_word.operation == kft_pkg::OP_READ);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled result word changed or dropped");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> (rsp_word.status == kft_pkg::ST_OK) || (rsp_word.status == kft_pkg::ST_FULL)
                   || (rsp_word.status == kft_pkg::ST_RANGE))
      else $error("result status is a reserved code");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_word.found |-> rsp_word.status == kft_pkg::ST_OK)
      else $error("match reported together with an error status");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && (rsp_word.status != kft_pkg::ST_OK) |->
         !rsp_word.found && (rsp_word.position == '0) && (rsp_word.entry_count == '0)
         && (rsp_word.entry_key == '0))
      else $error("error result carries entry data");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && req_seen |->
         rsp_word.entries_used <= kft_pkg::FILL_BITS'(kft_pkg::TABLE_DEPTH))
      else $error("entry count beyond table depth");

endmodule

bind kmer_frequency_table_core kft_checker u_kft_checker (.*);

@@ tb/tb_kmer_frequency_table_core.sv @@
// testbench of the k-mer table core: directed table, then random words checked by a predictor
module tb_kmer_frequency_table_core;

   localparam logic [1:0] OP_RESERVED = 2'd3;
   localparam int NO_SLOT = -1;
   localparam int ROWS = 21;
   localparam int PHASE_WORDS = 517;
   localparam int STALL_LIMIT = 5000;
   localparam int TAIL_CYCLES = 300;

   localparam logic [kft_pkg::KEY_BITS-1:0] KEY_ONES = {kft_pkg::KEY_BITS{1'b1}};
   localparam logic [kft_pkg::KEY_BITS-1:0] KEY_ACGT = 64'h4143_4754_4143_4754;
   localparam logic [kft_pkg::KEY_BITS-1:0] KEY_A    = 64'h4100_0000_0000_0000;
   localparam logic [kft_pkg::KEY_BITS-1:0] KEY_ODD  = 64'h8000_0000_0000_0001;
   localparam logic [kft_pkg::COUNT_BITS-1:0] CMAX   = kft_pkg::COUNT_MAX;
   localparam logic [1:0] OP_APPEND = kft_pkg::OP_APPEND;
   localparam logic [1:0] OP_FIND   = kft_pkg::OP_FIND;
   localparam logic [1:0] OP_READ   = kft_pkg::OP_READ;
   localparam logic [1:0] ST_OK     = kft_pkg::ST_OK;
   localparam logic [1:0] ST_RANGE  = kft_pkg::ST_RANGE;
   localparam kft_pkg::rsp_type NO_ANSWER = '0;

   typedef struct packed {
      bit               typed;
      kft_pkg::req_type word;
      kft_pkg::rsp_type answer;
   } script_row;

   localparam script_row SCRIPT [ROWS] = '{
      {1'b1, OP_READ, 64'h0, 31'd0, 8'd0, {1'b0, 8'd0, 64'h0, 31'd0, 9'd0, ST_RANGE}},
      {1'b1, OP_FIND, KEY_ONES, CMAX, 8'hFF, {1'b0, 8'd0, 64'h0, 31'd0, 9'd0, ST_OK}},
      {1'b1, OP_RESERVED, KEY_ONES, CMAX, 8'hFF,
         {1'b0, 8'd0, 64'h0, 31'd0, 9'd0, ST_OK}},
      {1'b1, OP_APPEND, KEY_ONES, CMAX, 8'd0,
         {1'b0, 8'd0, KEY_ONES, CMAX, 9'd1, ST_OK}},
      {1'b1, OP_APPEND, KEY_ONES, 31'd1, 8'd0, {1'b1, 8'd0, KEY_ONES, CMAX, 9'd1, ST_OK}},
      {1'b1, OP_APPEND, 64'h0, 31'd0, 8'hFF, {1'b0, 8'd1, 64'h0, 31'd0, 9'd2, ST_OK}},
      {1'b0, OP_APPEND, KEY_ACGT, 31'd5, 8'd0, NO_ANSWER},
      {1'b0, OP_APPEND, KEY_ACGT, 31'd7, 8'd9, NO_ANSWER},
      {1'b0, OP_FIND, KEY_ACGT, 31'd0, 8'd0, NO_ANSWER},
      {1'b0, OP_FIND, 64'h0, CMAX, 8'd0, NO_ANSWER},
      {1'b0, OP_READ, KEY_ONES, 31'd3, 8'd2, NO_ANSWER},
      {1'b1, OP_READ, 64'h0, 31'd0, 8'd3, {1'b0, 8'd0, 64'h0, 31'd0, 9'd3, ST_RANGE}},
      {1'b1, OP_READ, KEY_ONES, CMAX, 8'hFF, {1'b0, 8'd0, 64'h0, 31'd0, 9'd3, ST_RANGE}},
      {1'b1, OP_RESERVED, KEY_ACGT, 31'd1, 8'd1, {1'b0, 8'd0, 64'h0, 31'd0, 9'd3, ST_OK}},
      {1'b0, OP_APPEND, 64'h0, CMAX, 8'd0, NO_ANSWER},
      {1'b0, OP_APPEND, 64'h0, 31'd1, 8'd0, NO_ANSWER},
      {1'b0, OP_FIND, KEY_ODD, 31'd0, 8'd0, NO_ANSWER},
      {1'b0, OP_APPEND, KEY_A, 31'h4000_0000, 8'd0, NO_ANSWER},
      {1'b0, OP_APPEND, KEY_A, 31'h4000_0000, 8'd0, NO_ANSWER},
      {1'b0, OP_READ, 64'h0, 31'd0, 8'd0, NO_ANSWER},
      {1'b0, OP_READ, KEY_ONES, 31'd0, 8'd1, NO_ANSWER}
   };

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   kft_pkg::req_type req_word = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   kft_pkg::rsp_type rsp_word;

   int unsigned send_idle_pct = 21;
   int unsigned rsp_idle_pct = 80;
   int unsigned error_count = 0;
   int unsigned quiet_cycles = 0;

   logic [kft_pkg::KEY_BITS-1:0]   slot_key [kft_pkg::TABLE_DEPTH];
   logic [kft_pkg::COUNT_BITS-1:0] slot_count [kft_pkg::TABLE_DEPTH];
   int                             used_slots = 0;
   kft_pkg::rsp_type               awaited_results [$];
   kft_pkg::rsp_type               oldest;

   kmer_frequency_table_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_error(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want)
         report_error($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   // updates the table copy with one word and returns the result it must produce
   function automatic kft_pkg::rsp_type apply_word(input kft_pkg::req_type w);
      kft_pkg::rsp_type               r;
      logic [kft_pkg::KEY_BITS-1:0]   k;
      logic [kft_pkg::COUNT_BITS:0]   sum;
      int                             slot;
      int                             i;
      r = '0;
      k = w.key & kft_pkg::KEY_MASK;
      slot = NO_SLOT;
      for (i = used_slots - 1; i >= 0; i--)
         if (slot_key[i] == k) slot = i;
      case (w.operation)
         kft_pkg::OP_APPEND: begin
            if (slot != NO_SLOT) begin
               sum = {1'b0, slot_count[slot]} + {1'b0, w.frequency};
               slot_count[slot] = sum[kft_pkg::COUNT_BITS] ? kft_pkg::COUNT_MAX
                                                          : sum[kft_pkg::COUNT_BITS-1:0];
               r.found = 1'b1;
               r.position = kft_pkg::ADDR_BITS'(slot);
               r.entry_key = slot_key[slot];
               r.entry_count = slot_count[slot];
            end else if (used_slots < kft_pkg::TABLE_DEPTH) begin
               slot_key[used_slots] = k;
               slot_count[used_slots] = w.frequency;
               r.position = kft_pkg::ADDR_BITS'(used_slots);
               r.entry_key = k;
               r.entry_count = w.frequency;
               used_slots++;
            end else begin
               r.status = kft_pkg::ST_FULL;
            end
         end
         kft_pkg::OP_FIND: begin
            if (slot != NO_SLOT) begin
               r.found = 1'b1;
               r.position = kft_pkg::ADDR_BITS'(slot);
               r.entry_key = slot_key[slot];
               r.entry_count = slot_count[slot];
            end
         end
         kft_pkg::OP_READ: begin
            if (int'(w.index) < used_slots) begin
               r.position = w.index;
               r.entry_key = slot_key[w.index];
               r.entry_count = slot_count[w.index];
            end else begin
               r.status = kft_pkg::ST_RANGE;
            end
         end
         default: ;
      endcase
      r.entries_used = kft_pkg::FILL_BITS'(used_slots);
      return r;
   endfunction

   // mostly keys already in the table, the rest fresh keys, stray reads and reserved codes
   function automatic kft_pkg::req_type random_word();
      kft_pkg::req_type w;
      int unsigned      pick;
      w.operation = OP_RESERVED;
      w.key = {$urandom, $urandom};
      w.frequency = kft_pkg::COUNT_BITS'($urandom);
      w.index = kft_pkg::ADDR_BITS'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         w.operation = kft_pkg::OP_APPEND;
         if (used_slots > 0 && $urandom_range(0, 1) == 1)
            w.key = slot_key[$urandom_range(0, used_slots - 1)];
         case ($urandom_range(0, 3))
            0, 1: w.frequency = kft_pkg::COUNT_BITS'($urandom_range(0, 1000));
            2: w.frequency = kft_pkg::COUNT_MAX - kft_pkg::COUNT_BITS'($urandom_range(0, 3));
            default: ;
         endcase
      end else if (pick < 70) begin
         w.operation = kft_pkg::OP_FIND;
         if (used_slots > 0 && $urandom_range(0, 9) < 7)
            w.key = slot_key[$urandom_range(0, used_slots - 1)];
      end else if (pick < 95) begin
         w.operation = kft_pkg::OP_READ;
         if (used_slots > 0 && $urandom_range(0, 9) < 8)
            w.index = kft_pkg::ADDR_BITS'($urandom_range(0, used_slots - 1));
      end
      return w;
   endfunction

   task automatic send_word(input kft_pkg::req_type w, input bit typed,
                            input kft_pkg::rsp_type answer);
      kft_pkg::rsp_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
      predicted = apply_word(w);
      awaited_results.push_back(typed ? answer : predicted);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_results.size() != 0);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               report_error("result with nothing awaited");
            end else begin
               oldest = awaited_results.pop_front();
               check_field("found", 64'(rsp_word.found), 64'(oldest.found));
               check_field("position", 64'(rsp_word.position), 64'(oldest.position));
               check_field("entry_key", rsp_word.entry_key, oldest.entry_key);
               check_field("entry_count", 64'(rsp_word.entry_count),
                           64'(oldest.entry_count));
               check_field("entries_used", 64'(rsp_word.entries_used),
                           64'(oldest.entries_used));
               check_field("status", 64'(rsp_word.status), 64'(oldest.status));
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
      end
   end

   initial begin
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin
      int n;
      int p;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      for (n = 0; n < ROWS; n++)
         send_word(SCRIPT[n].word, SCRIPT[n].typed, SCRIPT[n].answer);
      drain_results();
      for (p = 0; p < 3; p++) begin
         case (p)
            0: begin
               send_idle_pct = 21;
               rsp_idle_pct = 80;
            end
            1: begin
               send_idle_pct = 80;
               rsp_idle_pct = 21;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         for (n = 0; n < PHASE_WORDS; n++)
            send_word(random_word(), 1'b0, NO_ANSWER);
         drain_results();
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
